>>> rtl/core/pbdc_pkg.sv
// Shared constants, types and decode helpers for the pileup base depth counter.
package pbdc_pkg;

   localparam int COUNT_BITS     = 24;
   localparam int INDEL_LEN_BITS = 16;
   localparam int NUM_BASES      = 5;
   localparam int BASE_BITS      = 3;
   localparam int CHAR_BITS      = 8;
   localparam int STRAND_BITS    = 2;

   localparam int REQ_DATA_BITS  = 2 * CHAR_BITS;
   localparam int RSP_FIELD_BITS = (NUM_BASES + 2) * COUNT_BITS + 2 * BASE_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [COUNT_BITS-1:0]     COUNT_MAX = '1;
   localparam logic [INDEL_LEN_BITS-1:0] LEN_MAX   = '1;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef count_type [NUM_BASES-1:0] count_vec_type;

   typedef enum logic [STRAND_BITS-1:0] {
      STRAND_ALL,
      STRAND_FWD,
      STRAND_REV
   } strand_type;

   localparam logic [BASE_BITS-1:0] BASE_A = 3'd0;
   localparam logic [BASE_BITS-1:0] BASE_C = 3'd1;
   localparam logic [BASE_BITS-1:0] BASE_G = 3'd2;
   localparam logic [BASE_BITS-1:0] BASE_T = 3'd3;
   localparam logic [BASE_BITS-1:0] BASE_N = 3'd4;

   localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_CARET  = 8'h5E;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UP_C   = 8'h43;
   localparam logic [CHAR_BITS-1:0] CH_UP_G   = 8'h47;
   localparam logic [CHAR_BITS-1:0] CH_UP_T   = 8'h54;
   localparam logic [CHAR_BITS-1:0] CH_UP_N   = 8'h4E;
   localparam logic [CHAR_BITS-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOW_C  = 8'h63;
   localparam logic [CHAR_BITS-1:0] CH_LOW_G  = 8'h67;
   localparam logic [CHAR_BITS-1:0] CH_LOW_T  = 8'h74;
   localparam logic [CHAR_BITS-1:0] CH_LOW_N  = 8'h6E;
   localparam logic [CHAR_BITS-1:0] CH_LOW_Z  = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CASE_DIFF = 8'h20;

   // Upper-cases the character, then maps A/C/G/T to 0..3 and anything else to N.
   function automatic logic [BASE_BITS-1:0] base_code(input logic [CHAR_BITS-1:0] ch);
      logic [CHAR_BITS-1:0] up;
      logic [BASE_BITS-1:0] code;
      up = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_DIFF : ch;
      case (up)
         CH_UP_A: code = BASE_A;
         CH_UP_C: code = BASE_C;
         CH_UP_G: code = BASE_G;
         CH_UP_T: code = BASE_T;
         default: code = BASE_N;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/core/pileup_base_depth_counter_core.sv
// Pileup base depth counter: character decode, strand counters and result sequencer.
// Throughput: one character transfer per cycle, except while a snapshot drains. A
// position-end (or empty) transfer latches the counters into a snapshot; its three
// results (all, forward, reverse) are loaded in turn from the snapshot into the single
// output register. While a snapshot is draining intake waits, taking the next transfer
// as the reverse result loads. Synchronous reset clears the counters, parse state,
// snapshot valid and output valid.
module pileup_base_depth_counter_core
   import pbdc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // char_code, ref_char
   input  logic                     req_tlast,  // end_of_position
   input  logic                     req_tuser,  // empty_position
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // count_a, count_c, count_g, count_t,
                                                // count_n, depth_total, match_count,
                                                // majority_base, ref_code, zero pad
   output logic                     rsp_tlast,  // last_of_run
   output logic [STRAND_BITS-1:0]   rsp_tuser   // strand_sel
);

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_LENGTH,
      MODE_SKIP
   } mode_type;

   localparam int ACC_BITS = INDEL_LEN_BITS + 4;
   localparam int SUM_BITS = COUNT_BITS + 3;

   mode_type                   mode_ff, mode_in;
   logic [INDEL_LEN_BITS-1:0]  rem_ff, rem_in;
   count_vec_type              fwd_ff, fwd_in, rev_ff, rev_in;
   count_vec_type              snap_fwd_ff, snap_fwd_in, snap_rev_ff, snap_rev_in;
   logic [BASE_BITS-1:0]       snap_ref_ff, snap_ref_in;
   logic                       snap_vld_ff, snap_vld_in;
   strand_type                 snap_idx_ff, snap_idx_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   strand_type                 rsp_strand_ff, rsp_strand_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [CHAR_BITS-1:0]       ch;
   logic [BASE_BITS-1:0]       ref_code;
   logic                       req_fire, pos_end, rsp_load, snap_free;
   logic                       decode, bump_fwd, bump_rev;
   logic [BASE_BITS-1:0]       bump_idx;
   logic [INDEL_LEN_BITS-1:0]  rem_dec;
   logic [ACC_BITS-1:0]        acc;
   logic                       is_digit;
   mode_type                   mode_upd;
   logic [INDEL_LEN_BITS-1:0]  rem_upd;
   count_vec_type              fwd_upd, rev_upd;
   count_vec_type              cur;
   logic [COUNT_BITS:0]        pair_sum;
   logic [SUM_BITS-1:0]        total_sum;
   count_type                  total, match, best;
   logic [BASE_BITS-1:0]       maj;

   assign ch       = req_tdata[CHAR_BITS-1:0];
   assign ref_code = base_code(req_tdata[REQ_DATA_BITS-1:CHAR_BITS]);
   assign pos_end  = req_tlast | req_tuser;
   assign req_fire = req_tvalid & req_tready;

   assign rsp_load   = snap_vld_ff & (~rsp_vld_ff | rsp_tready);
   assign snap_free  = rsp_load & (snap_idx_ff == STRAND_REV);
   assign req_tready = ~snap_vld_ff | snap_free;

   // Character decode and parse state update.
   always_comb begin
      mode_upd = mode_ff;
      rem_upd  = rem_ff;
      fwd_upd  = fwd_ff;
      rev_upd  = rev_ff;
      decode   = 1'b0;
      bump_fwd = 1'b0;
      bump_rev = 1'b0;
      bump_idx = BASE_N;
      rem_dec  = (rem_ff != '0) ? rem_ff - INDEL_LEN_BITS'(1) : '0;
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      acc      = (ACC_BITS'(rem_ff) << 3) + (ACC_BITS'(rem_ff) << 1)
                 + ACC_BITS'(ch[3:0] - CH_ZERO[3:0]);

      case (mode_ff)
         MODE_SKIP: begin
            rem_upd = rem_dec;
            if (rem_dec == '0) mode_upd = MODE_NORMAL;
         end
         MODE_LENGTH: begin
            if (is_digit) begin
               rem_upd = (acc > ACC_BITS'(LEN_MAX)) ? LEN_MAX : acc[INDEL_LEN_BITS-1:0];
            end else if (rem_ff != '0) begin
               // the first non-digit is the first skipped character
               rem_upd  = rem_dec;
               mode_upd = (rem_dec != '0) ? MODE_SKIP : MODE_NORMAL;
            end else begin
               mode_upd = MODE_NORMAL;
               decode   = 1'b1;
            end
         end
         default: decode = 1'b1;
      endcase

      if (decode) begin
         case (ch)
            CH_DOT: begin
               bump_fwd = 1'b1;
               bump_idx = ref_code;
            end
            CH_COMMA: begin
               bump_rev = 1'b1;
               bump_idx = ref_code;
            end
            CH_UP_A, CH_UP_C, CH_UP_G, CH_UP_T, CH_UP_N: begin
               bump_fwd = 1'b1;
               bump_idx = base_code(ch);
            end
            CH_LOW_A, CH_LOW_C, CH_LOW_G, CH_LOW_T, CH_LOW_N: begin
               bump_rev = 1'b1;
               bump_idx = base_code(ch);
            end
            CH_PLUS, CH_MINUS: begin
               mode_upd = MODE_LENGTH;
               rem_upd  = '0;
            end
            CH_CARET: begin
               mode_upd = MODE_SKIP;
               rem_upd  = INDEL_LEN_BITS'(1);
            end
            default: ;
         endcase
      end

      for (int i = 0; i < NUM_BASES; i++) begin
         if (bump_fwd && bump_idx == BASE_BITS'(i) && fwd_ff[i] != COUNT_MAX)
            fwd_upd[i] = fwd_ff[i] + COUNT_BITS'(1);
         if (bump_rev && bump_idx == BASE_BITS'(i) && rev_ff[i] != COUNT_MAX)
            rev_upd[i] = rev_ff[i] + COUNT_BITS'(1);
      end
   end

   // Result build from the snapshot for the strand being sent.
   always_comb begin
      for (int i = 0; i < NUM_BASES; i++) begin
         pair_sum = {1'b0, snap_fwd_ff[i]} + {1'b0, snap_rev_ff[i]};
         case (snap_idx_ff)
            STRAND_FWD: cur[i] = snap_fwd_ff[i];
            STRAND_REV: cur[i] = snap_rev_ff[i];
            default:    cur[i] = pair_sum[COUNT_BITS] ? COUNT_MAX : pair_sum[COUNT_BITS-1:0];
         endcase
      end
      total_sum = '0;
      for (int i = 0; i < NUM_BASES; i++) total_sum = total_sum + SUM_BITS'(cur[i]);
      total = (total_sum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : total_sum[COUNT_BITS-1:0];
      match = cur[snap_ref_ff];
      best  = cur[0];
      maj   = BASE_A;
      for (int i = 1; i < NUM_BASES; i++) begin
         if (cur[i] > best) begin
            best = cur[i];
            maj  = BASE_BITS'(i);
         end
      end
   end

   // Next-state selection for all registers.
   always_comb begin
      mode_in       = mode_ff;
      rem_in        = rem_ff;
      fwd_in        = fwd_ff;
      rev_in        = rev_ff;
      snap_fwd_in   = snap_fwd_ff;
      snap_rev_in   = snap_rev_ff;
      snap_ref_in   = snap_ref_ff;
      snap_vld_in   = snap_vld_ff;
      snap_idx_in   = snap_idx_ff;
      rsp_vld_in    = rsp_vld_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_strand_in = rsp_strand_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_load) begin
         rsp_vld_in    = 1'b1;
         rsp_data_in   = RSP_DATA_BITS'({snap_ref_ff, maj, match, total, cur});
         rsp_strand_in = snap_idx_ff;
         rsp_last_in   = (snap_idx_ff == STRAND_REV);
         case (snap_idx_ff)
            STRAND_ALL: snap_idx_in = STRAND_FWD;
            STRAND_FWD: snap_idx_in = STRAND_REV;
            default:    snap_vld_in = 1'b0;
         endcase
      end

      if (req_fire) begin
         if (pos_end) begin
            // empty position ignores its character
            snap_fwd_in = req_tuser ? fwd_ff : fwd_upd;
            snap_rev_in = req_tuser ? rev_ff : rev_upd;
            snap_ref_in = ref_code;
            snap_vld_in = 1'b1;
            snap_idx_in = STRAND_ALL;
            fwd_in      = '0;
            rev_in      = '0;
            mode_in     = MODE_NORMAL;
            rem_in      = '0;
         end else begin
            fwd_in  = fwd_upd;
            rev_in  = rev_upd;
            mode_in = mode_upd;
            rem_in  = rem_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         rem_ff      <= '0;
         fwd_ff      <= '0;
         rev_ff      <= '0;
         snap_vld_ff <= 1'b0;
         snap_idx_ff <= STRAND_ALL;
         rsp_vld_ff  <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         rem_ff      <= rem_in;
         fwd_ff      <= fwd_in;
         rev_ff      <= rev_in;
         snap_vld_ff <= snap_vld_in;
         snap_idx_ff <= snap_idx_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      snap_fwd_ff   <= snap_fwd_in;
      snap_rev_ff   <= snap_rev_in;
      snap_ref_ff   <= snap_ref_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_strand_ff <= rsp_strand_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_strand_ff;

   // Position end starts a fresh snapshot and leaves cleared counters behind.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && pos_end |=> snap_vld_ff && snap_idx_ff == STRAND_ALL
                              && fwd_ff == '0 && rev_ff == '0 && mode_ff == MODE_NORMAL)
      else $error("position end did not clear counters or arm snapshot");

   // Only the reverse result closes a position.
   a_last_rev: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_last_ff == (rsp_strand_ff == STRAND_REV))
      else $error("last_of_run not aligned with reverse strand result");

   // Intake never overwrites a snapshot that still has results to send.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire && snap_vld_ff |-> rsp_load && snap_idx_ff == STRAND_REV)
      else $error("snapshot overwritten before drained");

   // Results of one position come in strand order.
   a_strand_order: assert property (@(posedge clock) disable iff (reset)
      rsp_load && snap_idx_ff == STRAND_ALL |=> snap_vld_ff && snap_idx_ff == STRAND_FWD)
      else $error("strand sequence broken");

endmodule
